FILE: rtl/i2p_pkg.sv
// Shared constants and helpers for the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] PREC_NONE  = 3'd0;
  localparam logic [2:0] PREC_OPEN  = 3'd1;
  localparam logic [2:0] PREC_CLOSE = 3'd2;
  localparam logic [2:0] PREC_ADD   = 3'd3;
  localparam logic [2:0] PREC_MUL   = 3'd4;
  localparam logic [2:0] PREC_POW   = 3'd5;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  function automatic logic [2:0] prec(input logic [7:0] c);
    logic [2:0] p;
    unique case (c)
      CH_OPEN:                  p = PREC_OPEN;
      CH_CLOSE:                 p = PREC_CLOSE;
      CH_PLUS, CH_MINUS:        p = PREC_ADD;
      CH_MUL, CH_DIV, CH_MOD:   p = PREC_MUL;
      CH_POW:                   p = PREC_POW;
      default:                  p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/i2p_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/infix_to_postfix_converter.sv
// Infix-to-postfix converter: operator-stack sequencer with a RAM-backed stack.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+---------------------------------------------
//   s_*      | in  | s_tvalid/s_tready| tdata = in_symbol, tlast = expr_end
//   m_*      | out | m_tvalid/m_tready| tdata = out_symbol, tlast = run_last,
//            |     |                  | tuser = expr_done, error_code
//
// One transaction at a time: a plain character passes through ST_SYM, ST_TAIL and ST_FLUSH
// before the next acceptance; an operator pops entries in ST_POPOP (pop, then the RAM read in
// ST_FETCH that refills the top register) and is then pushed in ST_PUSH; the implied close
// parenthesis of expr_end pops operators the same way in ST_CLOSE, and ST_FINISH re-arms the stack.
// After reset, the ST_INIT state writes the bottom open parenthesis into the stack RAM.
// A stalled output holds the sequencer when a further result must be produced while the pending slot is full.
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_symbol
  input  wire logic       s_tlast,   // expr_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] out_symbol
  output logic            m_tlast,   // run_last
  output logic      [2:0] m_tuser    // [0] expr_done, [2:1] error_code
);

  import i2p_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SYM    = 4'd2;
  localparam logic [3:0] ST_PUSH   = 4'd3;
  localparam logic [3:0] ST_POPOP  = 4'd4;
  localparam logic [3:0] ST_CLOSE  = 4'd5;
  localparam logic [3:0] ST_FETCH  = 4'd6;
  localparam logic [3:0] ST_TAIL   = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;
  localparam logic [3:0] ST_FLUSH  = 4'd9;

  logic [3:0]     state, state_next;
  logic [3:0]     ret, ret_next;
  logic [SPW-1:0] sp, sp_next;
  logic [7:0]     top, top_next;
  logic [7:0]     sym, sym_next;
  logic [2:0]     prec_q, prec_q_next;
  logic           end_q, end_q_next;
  logic           phase_b, phase_b_next;
  logic           pend_valid, pend_valid_next;
  logic [7:0]     pend_sym, pend_sym_next;
  logic [1:0]     pend_err, pend_err_next;
  logic           m_tvalid_next;
  logic [7:0]     m_tdata_next;
  logic           m_tlast_next;
  logic [2:0]     m_tuser_next;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [SPW-1:0] below_top;

  logic           out_free;
  logic           emit_ok;
  logic           emit;
  logic [7:0]     emit_sym;
  logic [1:0]     emit_err;
  logic           stack_full;
  logic [3:0]     after_close;

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign s_tready    = (state == ST_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign emit_ok     = !pend_valid || out_free;
  assign stack_full  = (sp == SPW'(STACK_DEPTH));
  assign below_top   = sp - SPW'(2);
  assign ram_raddr   = below_top[AW-1:0];
  assign after_close = phase_b ? ST_FINISH : ST_TAIL;

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    sp_next         = sp;
    top_next        = top;
    sym_next        = sym;
    prec_q_next     = prec_q;
    end_q_next      = end_q;
    phase_b_next    = phase_b;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_err_next   = pend_err;
    m_tvalid_next   = m_tvalid;
    m_tdata_next    = m_tdata;
    m_tlast_next    = m_tlast;
    m_tuser_next    = m_tuser;
    ram_we          = 1'b0;
    ram_waddr       = sp[AW-1:0];
    ram_wdata       = sym;
    emit            = 1'b0;
    emit_sym        = CH_NUL;
    emit_err        = ERR_NONE;

    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end

    unique case (state)
      ST_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = CH_OPEN;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          sym_next     = s_tdata;
          end_q_next   = s_tlast;
          prec_q_next  = prec(s_tdata);
          phase_b_next = 1'b0;
          state_next   = ST_SYM;
        end
      end
      ST_SYM: begin
        unique case (prec_q)
          PREC_NONE: begin
            if (emit_ok) begin
              emit       = 1'b1;
              emit_sym   = sym;
              state_next = ST_TAIL;
            end
          end
          PREC_OPEN:  state_next = ST_PUSH;
          PREC_CLOSE: state_next = ST_CLOSE;
          default:    state_next = ST_POPOP;
        endcase
      end
      ST_PUSH: begin
        if (stack_full) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_err   = ERR_FULL;
            state_next = ST_TAIL;
          end
        end else begin
          ram_we     = 1'b1;
          sp_next    = sp + SPW'(1);
          top_next   = sym;
          state_next = ST_TAIL;
        end
      end
      ST_POPOP: begin
        if ((sp != '0) && (prec(top) >= prec_q)) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_sym   = top;
            sp_next    = sp - SPW'(1);
            ret_next   = ST_POPOP;
            state_next = ST_FETCH;
          end
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_CLOSE: begin
        if (sp == '0) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_err   = ERR_UNMATCHED;
            state_next = after_close;
          end
        end else if (top == CH_OPEN) begin
          sp_next    = sp - SPW'(1);
          ret_next   = after_close;
          state_next = ST_FETCH;
        end else if (emit_ok) begin
          emit       = 1'b1;
          emit_sym   = top;
          sp_next    = sp - SPW'(1);
          ret_next   = ST_CLOSE;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // The read issued with the pop returns the entry that is now on top.
        top_next   = ram_rdata;
        state_next = ret;
      end
      ST_TAIL: begin
        if (end_q) begin
          phase_b_next = 1'b1;
          state_next   = ST_CLOSE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FINISH: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = CH_OPEN;
        sp_next    = SPW'(1);
        top_next   = CH_OPEN;
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (pend_valid) begin
          if (out_free) begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = pend_sym;
            m_tlast_next    = 1'b1;
            m_tuser_next    = {pend_err, end_q};
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end else if (end_q) begin
          // Nothing else came out of this expression end, so send a bare marker.
          if (out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = CH_NUL;
            m_tlast_next  = 1'b1;
            m_tuser_next  = {ERR_NONE, 1'b1};
            state_next    = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase

    // The newest result waits in the pending slot until it is known whether it is the last.
    if (emit) begin
      if (pend_valid) begin
        m_tvalid_next = 1'b1;
        m_tdata_next  = pend_sym;
        m_tlast_next  = 1'b0;
        m_tuser_next  = {pend_err, 1'b0};
      end
      pend_valid_next = 1'b1;
      pend_sym_next   = emit_sym;
      pend_err_next   = emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sp         <= SPW'(1);
      top        <= CH_OPEN;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      sp         <= sp_next;
      top        <= top_next;
      pend_valid <= pend_valid_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret      <= ret_next;
    sym      <= sym_next;
    prec_q   <= prec_q_next;
    end_q    <= end_q_next;
    phase_b  <= phase_b_next;
    pend_sym <= pend_sym_next;
    pend_err <= pend_err_next;
    m_tdata  <= m_tdata_next;
    m_tlast  <= m_tlast_next;
    m_tuser  <= m_tuser_next;
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending result left over when a new transaction can be accepted");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SYM)
    else $error("accepted transaction did not start the sequencer");

  a_finish_rearms: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> sp == SPW'(1) && top == CH_OPEN)
    else $error("stack not re-armed at expression end");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the infix-to-postfix converter: stream driver, result monitor and predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int MAX_RESULTS = 33;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 60;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;
  localparam logic [1:0] PH_BOTH = 2'd3;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic [1:0] phase;
  } infix_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       run_last;
    logic       expr_done;
    logic [1:0] err;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_symbol
  logic       s_tlast = 1'b0;    // expr_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_symbol
  logic       m_tlast;           // run_last
  logic [2:0] m_tuser;           // [0] expr_done, [2:1] error_code

  infix_t   infix_q[$];
  postfix_t postfix_q[$];
  postfix_t step_q[$];

  logic [7:0]  op_stack [STACK_DEPTH];
  int unsigned op_count;

  int sent_count = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int rx_stall_pct = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] rank(input logic [7:0] c);
    case (c)
      CH_OPEN:                return PREC_OPEN;
      CH_CLOSE:               return PREC_CLOSE;
      CH_PLUS, CH_MINUS:      return PREC_ADD;
      CH_MUL, CH_DIV, CH_MOD: return PREC_MUL;
      CH_POW:                 return PREC_POW;
      default:                return PREC_NONE;
    endcase
  endfunction

  function automatic void emit_sym(input logic [7:0] c, input logic [1:0] e);
    postfix_t r;
    r.sym = c;
    r.run_last = 1'b0;
    r.expr_done = 1'b0;
    r.err = e;
    if (step_q.size() < MAX_RESULTS) step_q.push_back(r);
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (op_count >= STACK_DEPTH) begin
      emit_sym(CH_NUL, ERR_FULL);
    end else begin
      op_stack[op_count] = c;
      op_count++;
    end
  endfunction

  // Pops down to the nearest open parenthesis; running dry leaves the stack empty.
  function automatic void close_group();
    logic [7:0] c;
    while (op_count > 0) begin
      op_count--;
      c = op_stack[op_count];
      if (c == CH_OPEN) return;
      emit_sym(c, ERR_NONE);
    end
    emit_sym(CH_NUL, ERR_UNMATCHED);
  endfunction

  function automatic void shunt_symbol(input logic [7:0] sym, input logic last);
    logic [2:0] p;
    postfix_t   r;
    step_q.delete();
    p = rank(sym);
    if (p == PREC_OPEN) begin
      push_op(sym);
    end else if (p == PREC_CLOSE) begin
      close_group();
    end else if (p >= PREC_ADD) begin
      while (op_count > 0 && rank(op_stack[op_count - 1]) >= p) begin
        op_count--;
        emit_sym(op_stack[op_count], ERR_NONE);
      end
      push_op(sym);
    end else begin
      emit_sym(sym, ERR_NONE);
    end
    if (last) begin
      close_group();
      op_stack[0] = CH_OPEN;
      op_count = 1;
      if (step_q.size() == 0) emit_sym(CH_NUL, ERR_NONE);
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      r.expr_done = last;
      step_q.push_back(r);
    end
    foreach (step_q[i]) postfix_q.push_back(step_q[i]);
  endfunction

  function automatic void add_item(input logic [7:0] c, input logic e);
    infix_t x;
    x.sym = c;
    x.last = e;
    x.phase = PH_NONE;
    infix_q.push_back(x);
  endfunction

  function automatic void mark_end();
    infix_t x;
    x = infix_q.pop_back();
    x.last = 1'b1;
    infix_q.push_back(x);
  endfunction

  function automatic logic [7:0] any_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (rank(c) != PREC_NONE);
    return c;
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      4:       return CH_MOD;
      default: return CH_POW;
    endcase
  endfunction

  function automatic void gen_operand(input int lvl);
    if (lvl > 0 && $urandom_range(0, 3) == 0) begin
      add_item(CH_OPEN, 1'b0);
      gen_expr(lvl - 1);
      add_item(CH_CLOSE, 1'b0);
    end else begin
      add_item(any_operand(), 1'b0);
    end
  endfunction

  function automatic void gen_expr(input int lvl);
    int terms;
    terms = $urandom_range(0, 3);
    gen_operand(lvl);
    repeat (terms) begin
      add_item(any_operator(), 1'b0);
      gen_operand(lvl);
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    infix_t nx;
    int     idle_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        shunt_symbol(s_tdata, s_tlast);
        sent_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        idle_pct = 0;
        if (infix_q.size() > 0) begin
          idle_pct = (infix_q[0].phase == PH_SEND) ? 80 :
                     (infix_q[0].phase == PH_BOTH) ? 12 : 0;
        end
        if (infix_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          nx = infix_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nx.sym;
          s_tlast <= nx.last;
          rx_stall_pct <= (nx.phase == PH_RECV) ? 80 : (nx.phase == PH_BOTH) ? 12 : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    postfix_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result: out_symbol=%h run_last=%b tuser=%b",
                 m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else begin
          want = postfix_q.pop_front();
          if (m_tdata !== want.sym) begin
            $error("out_symbol: expected %h, got %h", want.sym, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_tlast);
            fail_count++;
          end
          if (m_tuser[0] !== want.expr_done) begin
            $error("expr_done: expected %b, got %b", want.expr_done, m_tuser[0]);
            fail_count++;
          end
          if (m_tuser[2:1] !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, m_tuser[2:1]);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("infix_to_postfix_converter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_proc
    int     base;
    int     deep_len;
    int     total;
    int     n;
    infix_t x;

    op_stack[0] = CH_OPEN;
    op_count = 1;

    // Operand extremes with mixed precedence.
    add_item(8'h00, 1'b0);
    add_item(CH_PLUS, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(CH_MUL, 1'b0);
    add_item("c", 1'b1);
    // Power, minus, divide and modulo, with equal-precedence pops.
    add_item("x", 1'b0);
    add_item(CH_POW, 1'b0);
    add_item("y", 1'b0);
    add_item(CH_MINUS, 1'b0);
    add_item("z", 1'b0);
    add_item(CH_DIV, 1'b0);
    add_item("w", 1'b0);
    add_item(CH_MOD, 1'b0);
    add_item("v", 1'b1);
    // Close that empties the stack, an operator pushed onto the empty stack, then unmatched closes.
    add_item(CH_CLOSE, 1'b0);
    add_item(CH_PLUS, 1'b0);
    add_item("q", 1'b0);
    add_item(CH_CLOSE, 1'b1);
    // Unclosed parentheses discarded at the end of the expression.
    add_item(CH_OPEN, 1'b0);
    add_item(CH_OPEN, 1'b0);
    add_item("k", 1'b1);
    // Expression that produces nothing but the end marker.
    add_item(CH_OPEN, 1'b1);

    base = infix_q.size();
    deep_len = 0;
    while (infix_q.size() < base + deep_len + RANDOM_ITEMS) begin
      if (deep_len == 0 && infix_q.size() > base + RANDOM_ITEMS / 2) begin
        // Nesting deep enough to overflow the operator stack.
        n = infix_q.size();
        repeat (STACK_DEPTH - 1 + $urandom_range(0, 3)) add_item(CH_OPEN, 1'b0);
        add_item(any_operand(), 1'b0);
        add_item(any_operator(), 1'b0);
        add_item(CH_OPEN, 1'b0);
        add_item(any_operand(), 1'b0);
        add_item(CH_CLOSE, 1'b1);
        deep_len = infix_q.size() - n;
      end
      case ($urandom_range(0, 9))
        7: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0:       add_item(CH_OPEN, 1'b0);
              1:       add_item(CH_CLOSE, 1'b0);
              2:       add_item(any_operator(), 1'b0);
              default: add_item(any_operand(), 1'b0);
            endcase
          end
          mark_end();
        end
        8: add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        9: ;
        default: begin
          gen_expr($urandom_range(0, 3));
          mark_end();
        end
      endcase
    end
    mark_end();

    // Four idling phases in order across the item stream.
    total = infix_q.size();
    for (int i = 0; i < total; i++) begin
      x = infix_q[i];
      x.phase = 2'((i * 4) / total);
      infix_q[i] = x;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total) @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("infix_to_postfix_converter test passed");
    end else begin
      $display("infix_to_postfix_converter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
